// ===== rtl/fmacl_pkg.sv =====
// fmacl_pkg: shared types, constants and helpers for the first-match access list.
// Used by every module of the first_match_ip_acl_unit block but fmacl_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fmacl_pkg;

   localparam int NUM_RULES = 16;
   localparam int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int CNT_W     = $clog2(NUM_RULES + 1);

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int PLEN_W    = 6;
   localparam int RIDX_W    = 4;
   localparam int RCNT_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 5;
   localparam int MAX_PLEN  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ACL_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_COUNT  = 1'd1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_CHECK = 1'b1
   } cmd_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // one stored rule; addresses are kept already masked
   typedef struct packed {
      logic                action;
      logic [PLEN_W-1:0]   dst_plen;
      logic [PORT_W-1:0]   dst_port;
      logic [ADDR_W-1:0]   dst_addr;
      logic [PLEN_W-1:0]   src_plen;
      logic [PORT_W-1:0]   src_port;
      logic [ADDR_W-1:0]   src_addr;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   // controller to datapath
   typedef struct packed {
      logic             wr;
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             finish;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             enabled;
   } dp_cmd_type;

   function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLEN_W-1:0] len);
      logic [PLEN_W-1:0] res;
      res = (32'(len) > MAX_PLEN) ? PLEN_W'(MAX_PLEN) : len;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
      logic [ADDR_W-1:0] res;
      res = ~({ADDR_W{1'b1}} >> sat_plen(len));
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/first_match_ip_acl_unit.sv =====
// Top level of the first-match IPv4 access list: joins fmacl_ctrl and fmacl_dp.
// Depends on fmacl_pkg, fmacl_ctrl, fmacl_dp and fmacl_ram.
//
// A word is taken when start is high and busy is low. A rule write (command 0)
// goes into the table at that edge, leaves busy low and returns nothing; writes
// to a slot at or beyond the table size are dropped. A check (command 1) scans
// rules 0 to rule_count-1 (rule_count saturated at the table size) one per cycle
// out of a table memory with one write port, one read port and registered read:
// busy stays high until the scan ends, at the first hit or after the last rule,
// and is high for one cycle only when the list is disabled or rule_count is 0. Its
// word appears on the rsp_ ports for exactly one cycle under rsp_valid, in the
// first cycle with busy low again, and the next word may be taken in that same
// cycle. The receiver cannot stall, so rsp_valid must be sampled every cycle.
// Slots never written read back as garbage.
// Write csr registers only while no check is in flight.
`timescale 1ns / 1ps
`default_nettype none

module first_match_ip_acl_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_command,
   input  wire logic [fmacl_pkg::RIDX_W-1:0]      req_rule_index,
   input  wire logic [fmacl_pkg::ADDR_W-1:0]      req_src_addr,
   input  wire logic [fmacl_pkg::PORT_W-1:0]      req_src_port,
   input  wire logic [fmacl_pkg::ADDR_W-1:0]      req_dst_addr,
   input  wire logic [fmacl_pkg::PORT_W-1:0]      req_dst_port,
   input  wire logic [fmacl_pkg::PLEN_W-1:0]      req_src_prefix_len,
   input  wire logic [fmacl_pkg::PLEN_W-1:0]      req_dst_prefix_len,
   input  wire logic                              req_permit,
   output logic                                   rsp_valid,
   output logic                                   rsp_blocked,
   output logic                                   rsp_matched,
   output logic [fmacl_pkg::RIDX_W-1:0]           rsp_hit_index,
   input  wire logic                              csr_wr_en,
   input  wire logic [fmacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fmacl_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   fmacl_pkg::dp_cmd_type cmd;
   logic                  match;

   fmacl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_rule_index (req_rule_index),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .match          (match),
      .cmd            (cmd)
   );

   fmacl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_rule_index     (req_rule_index),
      .req_src_addr       (req_src_addr),
      .req_src_port       (req_src_port),
      .req_dst_addr       (req_dst_addr),
      .req_dst_port       (req_dst_port),
      .req_src_prefix_len (req_src_prefix_len),
      .req_dst_prefix_len (req_dst_prefix_len),
      .req_permit         (req_permit),
      .match              (match),
      .rsp_valid          (rsp_valid),
      .rsp_blocked        (rsp_blocked),
      .rsp_matched        (rsp_matched),
      .rsp_hit_index      (rsp_hit_index)
   );

endmodule

`default_nettype wire

// ===== rtl/fmacl_ram.sv =====
// fmacl_ram: generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; holds the rule table of the access list.
`timescale 1ns / 1ps
`default_nettype none

module fmacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fmacl_dp.sv =====
// fmacl_dp: rule storage, connection capture, rule compare and result register.
// Depends on fmacl_pkg and fmacl_ram; driven by fmacl_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fmacl_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fmacl_pkg::dp_cmd_type              cmd,
   input  wire logic [fmacl_pkg::RIDX_W-1:0]       req_rule_index,
   input  wire logic [fmacl_pkg::ADDR_W-1:0]       req_src_addr,
   input  wire logic [fmacl_pkg::PORT_W-1:0]       req_src_port,
   input  wire logic [fmacl_pkg::ADDR_W-1:0]       req_dst_addr,
   input  wire logic [fmacl_pkg::PORT_W-1:0]       req_dst_port,
   input  wire logic [fmacl_pkg::PLEN_W-1:0]       req_src_prefix_len,
   input  wire logic [fmacl_pkg::PLEN_W-1:0]       req_dst_prefix_len,
   input  wire logic                               req_permit,
   output logic                                    match,
   output logic                                    rsp_valid,
   output logic                                    rsp_blocked,
   output logic                                    rsp_matched,
   output logic [fmacl_pkg::RIDX_W-1:0]            rsp_hit_index
);

   fmacl_pkg::rule_type                  wr_rule;
   fmacl_pkg::rule_type                  rd_rule;
   logic [fmacl_pkg::RULE_W-1:0]         rd_word;

   logic [fmacl_pkg::ADDR_W-1:0] src_addr_ff, src_addr_in;
   logic [fmacl_pkg::PORT_W-1:0] src_port_ff, src_port_in;
   logic [fmacl_pkg::ADDR_W-1:0] dst_addr_ff, dst_addr_in;
   logic [fmacl_pkg::PORT_W-1:0] dst_port_ff, dst_port_in;

   logic                         valid_ff, valid_in;
   logic                         blocked_ff, blocked_in;
   logic                         matched_ff, matched_in;
   logic [fmacl_pkg::RIDX_W-1:0] hit_index_ff, hit_index_in;

   logic src_ok, dst_ok;

   always_comb begin
      wr_rule.action   = req_permit;
      wr_rule.src_plen = fmacl_pkg::sat_plen(req_src_prefix_len);
      wr_rule.dst_plen = fmacl_pkg::sat_plen(req_dst_prefix_len);
      wr_rule.src_addr = req_src_addr & fmacl_pkg::prefix_mask(req_src_prefix_len);
      wr_rule.dst_addr = req_dst_addr & fmacl_pkg::prefix_mask(req_dst_prefix_len);
      wr_rule.src_port = req_src_port;
      wr_rule.dst_port = req_dst_port;
   end

   fmacl_ram #(
      .WIDTH (fmacl_pkg::RULE_W),
      .DEPTH (fmacl_pkg::NUM_RULES)
   ) u_rules (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (fmacl_pkg::IDX_W'(req_rule_index)),
      .wr_data (wr_rule),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_word)
   );

   assign rd_rule = fmacl_pkg::rule_type'(rd_word);

   // port 0 on either side is a wildcard
   always_comb begin
      src_ok = ((src_addr_ff & fmacl_pkg::prefix_mask(rd_rule.src_plen)) == rd_rule.src_addr)
               && (src_port_ff == rd_rule.src_port || src_port_ff == '0
                   || rd_rule.src_port == '0);
      dst_ok = ((dst_addr_ff & fmacl_pkg::prefix_mask(rd_rule.dst_plen)) == rd_rule.dst_addr)
               && (dst_port_ff == rd_rule.dst_port || dst_port_ff == '0
                   || rd_rule.dst_port == '0);
      match  = src_ok && dst_ok;
   end

   always_comb begin
      src_addr_in  = src_addr_ff;
      src_port_in  = src_port_ff;
      dst_addr_in  = dst_addr_ff;
      dst_port_in  = dst_port_ff;
      valid_in     = cmd.finish;
      blocked_in   = blocked_ff;
      matched_in   = matched_ff;
      hit_index_in = hit_index_ff;
      if (cmd.load) begin
         src_addr_in = req_src_addr;
         src_port_in = req_src_port;
         dst_addr_in = req_dst_addr;
         dst_port_in = req_dst_port;
      end
      if (cmd.finish) begin
         matched_in   = cmd.hit;
         hit_index_in = cmd.hit ? fmacl_pkg::RIDX_W'(cmd.hit_idx) : '0;
         blocked_in   = cmd.enabled && (cmd.hit ? !rd_rule.action : 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_addr_ff  <= src_addr_in;
      src_port_ff  <= src_port_in;
      dst_addr_ff  <= dst_addr_in;
      dst_port_ff  <= dst_port_in;
      blocked_ff   <= blocked_in;
      matched_ff   <= matched_in;
      hit_index_ff <= hit_index_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_blocked   = blocked_ff;
   assign rsp_matched   = matched_ff;
   assign rsp_hit_index = hit_index_ff;

endmodule

`default_nettype wire

// ===== rtl/fmacl_ctrl.sv =====
// fmacl_ctrl: control registers and the scan state machine of the access list.
// Depends on fmacl_pkg; commands fmacl_dp through fmacl_pkg::dp_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module fmacl_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_command,
   input  wire logic [fmacl_pkg::RIDX_W-1:0]      req_rule_index,
   input  wire logic                              csr_wr_en,
   input  wire logic [fmacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fmacl_pkg::CSR_DAT_W-1:0]   csr_wdata,
   input  wire logic                              match,
   output fmacl_pkg::dp_cmd_type                  cmd
);

   fmacl_pkg::state_type state_ff, state_in;

   logic                          enabled_ff, enabled_in;
   logic [fmacl_pkg::RCNT_W-1:0]  rule_count_ff, rule_count_in;

   logic [fmacl_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [fmacl_pkg::CNT_W-1:0]   limit_ff, limit_in;
   logic                          scan_en_ff, scan_en_in;
   logic                          pend_ff, pend_in;
   logic [fmacl_pkg::IDX_W-1:0]   pend_idx_ff, pend_idx_in;

   logic [fmacl_pkg::CNT_W-1:0]   count_sat;

   always_comb begin
      enabled_in    = enabled_ff;
      rule_count_in = rule_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fmacl_pkg::CSR_ACL_ENABLED: enabled_in    = csr_wdata[0];
            fmacl_pkg::CSR_RULE_COUNT:  rule_count_in = fmacl_pkg::RCNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign count_sat = (32'(rule_count_ff) > fmacl_pkg::NUM_RULES)
                      ? fmacl_pkg::CNT_W'(fmacl_pkg::NUM_RULES)
                      : fmacl_pkg::CNT_W'(rule_count_ff);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      limit_in    = limit_ff;
      scan_en_in  = scan_en_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      busy        = 1'b0;
      cmd         = '0;
      cmd.enabled = scan_en_ff;
      cmd.rd_addr = cnt_ff[fmacl_pkg::IDX_W-1:0];
      cmd.hit_idx = pend_idx_ff;
      case (state_ff)
         fmacl_pkg::S_IDLE: begin
            if (start) begin
               if (req_command == fmacl_pkg::CMD_CHECK) begin
                  cmd.load   = 1'b1;
                  cnt_in     = '0;
                  pend_in    = 1'b0;
                  scan_en_in = enabled_ff;
                  // a disabled list scans nothing
                  limit_in   = enabled_ff ? count_sat : '0;
                  state_in   = fmacl_pkg::S_SCAN;
               end else begin
                  cmd.wr = 32'(req_rule_index) < fmacl_pkg::NUM_RULES;
               end
            end
         end
         fmacl_pkg::S_SCAN: begin
            busy = 1'b1;
            // read of rule cnt overlaps the compare of rule pend_idx
            if (pend_ff && match) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = fmacl_pkg::S_IDLE;
            end else if (!pend_ff && cnt_ff >= limit_ff) begin
               cmd.finish = 1'b1;
               state_in   = fmacl_pkg::S_IDLE;
            end else if (cnt_ff < limit_ff) begin
               cmd.rd_en   = 1'b1;
               cnt_in      = cnt_ff + fmacl_pkg::CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[fmacl_pkg::IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
         end
         default: begin
            state_in = fmacl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fmacl_pkg::S_IDLE;
         enabled_ff    <= 1'b0;
         rule_count_ff <= '0;
         cnt_ff        <= '0;
         limit_ff      <= '0;
         scan_en_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         pend_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         rule_count_ff <= rule_count_in;
         cnt_ff        <= cnt_in;
         limit_ff      <= limit_in;
         scan_en_ff    <= scan_en_in;
         pend_ff       <= pend_in;
         pend_idx_ff   <= pend_idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for first_match_ip_acl_unit: directed rule table and checks, then
// random phases of rule writes and connection checks under several register settings.
// Depends on fmacl_pkg and the first_match_ip_acl_unit RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_RULES    = fmacl_pkg::NUM_RULES;
   localparam int MAX_PLEN     = fmacl_pkg::MAX_PLEN;
   localparam int ADDR_W       = fmacl_pkg::ADDR_W;
   localparam int PORT_W       = fmacl_pkg::PORT_W;
   localparam int PLEN_W       = fmacl_pkg::PLEN_W;
   localparam int RIDX_W       = fmacl_pkg::RIDX_W;
   localparam int RCNT_W       = fmacl_pkg::RCNT_W;
   localparam int CSR_IDX_W    = fmacl_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W    = fmacl_pkg::CSR_DAT_W;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 127;
   localparam int SETTLE       = 4;

   typedef fmacl_pkg::cmd_type cmd_type;

   typedef struct {
      cmd_type             cmd;
      logic [RIDX_W-1:0]   rule_idx;
      logic [ADDR_W-1:0]   src_addr;
      logic [PORT_W-1:0]   src_port;
      logic [ADDR_W-1:0]   dst_addr;
      logic [PORT_W-1:0]   dst_port;
      logic [PLEN_W-1:0]   src_plen;
      logic [PLEN_W-1:0]   dst_plen;
      logic                permit;
   } acl_word_type;

   typedef struct packed {
      logic                blocked;
      logic                matched;
      logic [RIDX_W-1:0]   hit;
   } verdict_type;

   typedef struct {
      logic [ADDR_W-1:0]   s_addr;
      logic [ADDR_W-1:0]   s_mask;
      logic [PORT_W-1:0]   s_port;
      logic [ADDR_W-1:0]   d_addr;
      logic [ADDR_W-1:0]   d_mask;
      logic [PORT_W-1:0]   d_port;
      logic                permit;
   } shadow_rule_type;

   typedef enum logic {
      ROW_WORD = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DAT_W-1:0]   csr_val;
      acl_word_type           w;
      logic                   has_exp;
      verdict_type            exp;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_command = 1'b0;
   logic [RIDX_W-1:0]      req_rule_index = '0;
   logic [ADDR_W-1:0]      req_src_addr = '0;
   logic [PORT_W-1:0]      req_src_port = '0;
   logic [ADDR_W-1:0]      req_dst_addr = '0;
   logic [PORT_W-1:0]      req_dst_port = '0;
   logic [PLEN_W-1:0]      req_src_prefix_len = '0;
   logic [PLEN_W-1:0]      req_dst_prefix_len = '0;
   logic                   req_permit = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_blocked;
   logic                   rsp_matched;
   logic [RIDX_W-1:0]      rsp_hit_index;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DAT_W-1:0]   csr_wdata = '0;

   shadow_rule_type  shadow_rules [NUM_RULES];
   logic             acl_on;
   logic [RCNT_W-1:0] active_rules;
   verdict_type      pending_verdicts [$];
   dir_row_type      directed_rows [$];
   int               mismatches = 0;
   int               cycles = 0;
   int               burst_left = 0;
   int               burst_gap = 0;

   first_match_ip_acl_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_rule_index     (req_rule_index),
      .req_src_addr       (req_src_addr),
      .req_src_port       (req_src_port),
      .req_dst_addr       (req_dst_addr),
      .req_dst_port       (req_dst_port),
      .req_src_prefix_len (req_src_prefix_len),
      .req_dst_prefix_len (req_dst_prefix_len),
      .req_permit         (req_permit),
      .rsp_valid          (rsp_valid),
      .rsp_blocked        (rsp_blocked),
      .rsp_matched        (rsp_matched),
      .rsp_hit_index      (rsp_hit_index),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[first_match_ip_acl_unit] ERROR");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic logic [ADDR_W-1:0] net_mask(input logic [PLEN_W-1:0] len);
      int n;
      n = (int'(len) > MAX_PLEN) ? MAX_PLEN : int'(len);
      return (n == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - n));
   endfunction

   function automatic bit side_hit(input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port,
                                   input logic [ADDR_W-1:0] r_addr,
                                   input logic [ADDR_W-1:0] r_mask,
                                   input logic [PORT_W-1:0] r_port);
      return ((addr & r_mask) == r_addr) && (port == r_port || port == '0 || r_port == '0);
   endfunction

   function automatic int scan_limit();
      return (int'(active_rules) > NUM_RULES) ? NUM_RULES : int'(active_rules);
   endfunction

   task automatic store_rule(input acl_word_type w);
      shadow_rule_type r;
      r.s_mask = net_mask(w.src_plen);
      r.s_addr = w.src_addr & r.s_mask;
      r.s_port = w.src_port;
      r.d_mask = net_mask(w.dst_plen);
      r.d_addr = w.dst_addr & r.d_mask;
      r.d_port = w.dst_port;
      r.permit = w.permit;
      if (int'(w.rule_idx) < NUM_RULES) begin
         shadow_rules[w.rule_idx] = r;
      end
   endtask

   function automatic verdict_type acl_verdict(input acl_word_type w);
      verdict_type v;
      v = '0;
      if (!acl_on) return v;
      for (int i = 0; i < scan_limit(); i++) begin
         if (side_hit(w.src_addr, w.src_port, shadow_rules[i].s_addr, shadow_rules[i].s_mask,
                      shadow_rules[i].s_port) &&
             side_hit(w.dst_addr, w.dst_port, shadow_rules[i].d_addr, shadow_rules[i].d_mask,
                      shadow_rules[i].d_port)) begin
            v.blocked = ~shadow_rules[i].permit;
            v.matched = 1'b1;
            v.hit     = RIDX_W'(i);
            return v;
         end
      end
      v.blocked = 1'b1;
      return v;
   endfunction

   // ---------------- result checking ----------------

   task automatic flag_field(input string name, input logic [RIDX_W-1:0] want,
                             input logic [RIDX_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word expected none got blocked=%0b matched=%0b hit=%0d",
                     $time, rsp_blocked, rsp_matched, rsp_hit_index);
         end else begin
            e = pending_verdicts.pop_front();
            flag_field("blocked", RIDX_W'(e.blocked), RIDX_W'(rsp_blocked));
            flag_field("matched", RIDX_W'(e.matched), RIDX_W'(rsp_matched));
            flag_field("hit_index", e.hit, rsp_hit_index);
         end
      end
   end

   // ---------------- drivers ----------------

   // sender runs in bursts with random gaps in between
   task automatic send_word(input acl_word_type w, input bit has_exp, input verdict_type exp);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         burst_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
         burst_gap = 0;
      end
      burst_left--;
      @(negedge clock);
      if (burst_gap > 0) begin
         start <= 1'b0;
         repeat (burst_gap) @(negedge clock);
      end
      start              <= 1'b1;
      req_command        <= w.cmd;
      req_rule_index     <= w.rule_idx;
      req_src_addr       <= w.src_addr;
      req_src_port       <= w.src_port;
      req_dst_addr       <= w.dst_addr;
      req_dst_port       <= w.dst_port;
      req_src_prefix_len <= w.src_plen;
      req_dst_prefix_len <= w.dst_plen;
      req_permit         <= w.permit;
      do @(posedge clock); while (busy !== 1'b0);
      if (w.cmd == fmacl_pkg::CMD_WRITE) begin
         store_rule(w);
      end else begin
         pending_verdicts.push_back(has_exp ? exp : acl_verdict(w));
      end
   endtask

   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      drain_block();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == fmacl_pkg::CSR_ACL_ENABLED) acl_on = val[0];
      else active_rules = RCNT_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------- stimulus ----------------

   function automatic acl_word_type mk_word(input cmd_type cmd, input int idx,
                                            input logic [ADDR_W-1:0] sa, input int spl,
                                            input logic [PORT_W-1:0] sp,
                                            input logic [ADDR_W-1:0] da, input int dpl,
                                            input logic [PORT_W-1:0] dp, input logic act);
      acl_word_type w;
      w.cmd      = cmd;
      w.rule_idx = RIDX_W'(idx);
      w.src_addr = sa;
      w.src_plen = PLEN_W'(spl);
      w.src_port = sp;
      w.dst_addr = da;
      w.dst_plen = PLEN_W'(dpl);
      w.dst_port = dp;
      w.permit   = act;
      return w;
   endfunction

   task automatic add_write(input int idx, input logic [ADDR_W-1:0] sa, input int spl,
                            input logic [PORT_W-1:0] sp, input logic [ADDR_W-1:0] da,
                            input int dpl, input logic [PORT_W-1:0] dp, input logic act);
      dir_row_type r;
      r.kind    = ROW_WORD;
      r.csr_idx = '0;
      r.csr_val = '0;
      r.w       = mk_word(fmacl_pkg::CMD_WRITE, idx, sa, spl, sp, da, dpl, dp, act);
      r.has_exp = 1'b0;
      r.exp     = '0;
      directed_rows.push_back(r);
   endtask

   // has_exp low leaves the verdict to the predictor
   task automatic add_check(input logic [ADDR_W-1:0] sa, input logic [PORT_W-1:0] sp,
                            input logic [ADDR_W-1:0] da, input logic [PORT_W-1:0] dp,
                            input logic has_exp, input logic b, input logic m, input int h);
      dir_row_type r;
      r.kind    = ROW_WORD;
      r.csr_idx = '0;
      r.csr_val = '0;
      r.w       = mk_word(fmacl_pkg::CMD_CHECK, int'($urandom_range(0, 15)), sa,
                          int'($urandom_range(0, 63)), sp, da,
                          int'($urandom_range(0, 63)), dp, 1'($urandom));
      r.has_exp = has_exp;
      r.exp     = '{blocked: b, matched: m, hit: RIDX_W'(h)};
      directed_rows.push_back(r);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      dir_row_type r;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = CSR_DAT_W'(val);
      r.w       = mk_word(fmacl_pkg::CMD_CHECK, 0, '0, 0, '0, '0, 0, '0, 1'b0);
      r.has_exp = 1'b0;
      r.exp     = '0;
      directed_rows.push_back(r);
   endtask

   function automatic acl_word_type random_word();
      acl_word_type w;
      int pick;
      int lim;
      int r;
      int b;
      w.cmd      = fmacl_pkg::CMD_CHECK;
      w.rule_idx = RIDX_W'($urandom);
      w.src_addr = $urandom;
      w.dst_addr = $urandom;
      w.src_port = PORT_W'($urandom);
      w.dst_port = PORT_W'($urandom);
      w.src_plen = PLEN_W'($urandom);
      w.dst_plen = PLEN_W'($urandom);
      w.permit   = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         w.cmd = fmacl_pkg::CMD_WRITE;
         if ($urandom_range(0, 9) != 0) w.src_plen = PLEN_W'($urandom_range(0, 32));
         if ($urandom_range(0, 9) != 0) w.dst_plen = PLEN_W'($urandom_range(0, 32));
         if ($urandom_range(0, 2) == 0) w.src_port = '0;
         if ($urandom_range(0, 2) == 0) w.dst_port = '0;
      end else if (pick < 90) begin
         // aim the check at one active rule (any slot when none is active), sometimes just missing it
         lim = scan_limit();
         r = (lim == 0) ? int'($urandom_range(0, NUM_RULES - 1)) : int'($urandom_range(0, lim - 1));
         w.src_addr = shadow_rules[r].s_addr | (w.src_addr & ~shadow_rules[r].s_mask);
         w.dst_addr = shadow_rules[r].d_addr | (w.dst_addr & ~shadow_rules[r].d_mask);
         case ($urandom_range(0, 3))
            0, 1: w.src_port = shadow_rules[r].s_port;
            2: w.src_port = '0;
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0, 1: w.dst_port = shadow_rules[r].d_port;
            2: w.dst_port = '0;
            default: ;
         endcase
         if ($urandom_range(0, 6) == 0) begin
            b = $urandom_range(0, ADDR_W - 1);
            if ($urandom_range(0, 1) == 0) w.src_addr[b] = ~w.src_addr[b];
            else w.dst_addr[b] = ~w.dst_addr[b];
         end
      end
      return w;
   endfunction

   initial begin
      int phase_count [PHASES];
      int cnt;
      dir_row_type row;

      phase_count  = '{16, 0, 1, 31, 16, 8, -1, 15, 16, -1};
      acl_on       = 1'b0;
      active_rules = '0;
      foreach (shadow_rules[i]) shadow_rules[i] = '{default: '0};

      // after reset: list off, no rules active
      add_check(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 0);
      add_csr(fmacl_pkg::CSR_ACL_ENABLED, 1);
      // enabled with an empty list: nothing matches
      add_check(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 0);
      add_write(0, 32'hFFFF_FFFF, 32, 16'hFFFF, 32'h0000_0000, 0, 16'h0000, 1'b1);
      add_write(1, 32'h0A00_0000, 8, 16'h0000, 32'hC0A8_0000, 16, 16'h0050, 1'b0);
      add_write(2, 32'h1234_5678, 63, 16'h0001, 32'h8765_4321, 40, 16'h0002, 1'b1);
      add_write(3, 32'hAAAA_AAAA, 1, 16'h8000, 32'h5555_5555, 31, 16'h7FFF, 1'b0);
      for (int i = 4; i < NUM_RULES - 1; i++) begin
         add_write(i, $urandom, int'($urandom_range(8, 32)), PORT_W'($urandom), $urandom,
                   int'($urandom_range(8, 32)), PORT_W'($urandom), 1'($urandom));
      end
      // last slot catches everything and denies
      add_write(NUM_RULES - 1, 32'h0, 0, 16'h0, 32'h0, 0, 16'h0, 1'b0);
      add_csr(fmacl_pkg::CSR_RULE_COUNT, 16);
      add_check(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 1'b1, 0);
      add_check(32'h0A12_3456, 16'h0000, 32'hC0A8_FFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 1);
      add_check(32'h1234_5678, 16'h0001, 32'h8765_4321, 16'h0002, 1'b1, 1'b0, 1'b1, 2);
      add_check(32'h1234_5678, 16'h0003, 32'h8765_4321, 16'h0002, 1'b0, 1'b0, 1'b0, 0);
      // count above the table size saturates
      add_csr(fmacl_pkg::CSR_RULE_COUNT, 31);
      add_check(32'h0102_0304, 16'h0063, 32'h0506_0708, 16'h0077, 1'b0, 1'b0, 1'b0, 0);
      add_csr(fmacl_pkg::CSR_RULE_COUNT, 3);
      add_check(32'hAAAA_AAAA, 16'h8000, 32'h5555_5554, 16'h7FFF, 1'b1, 1'b1, 1'b0, 0);
      add_csr(fmacl_pkg::CSR_RULE_COUNT, 4);
      add_check(32'hAAAA_AAAA, 16'h8000, 32'h5555_5554, 16'h7FFF, 1'b1, 1'b1, 1'b1, 3);
      // only bit 0 of the enable counts
      add_csr(fmacl_pkg::CSR_ACL_ENABLED, 5'b11110);
      add_check(32'hAAAA_AAAA, 16'h8000, 32'h5555_5554, 16'h7FFF, 1'b1, 1'b0, 1'b0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) write_csr(row.csr_idx, row.csr_val);
         else send_word(row.w, row.has_exp, row.exp);
      end

      for (int p = 0; p < PHASES; p++) begin
         cnt = (phase_count[p] < 0) ? int'($urandom_range(0, 31)) : phase_count[p];
         write_csr(fmacl_pkg::CSR_RULE_COUNT, CSR_DAT_W'(cnt));
         write_csr(fmacl_pkg::CSR_ACL_ENABLED,
                   {(CSR_DAT_W - 1)'($urandom), (p == 4) ? 1'b0 : 1'b1});
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_word(), 1'b0, '0);
         end
      end

      drain_block();
      repeat (NUM_RULES + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[first_match_ip_acl_unit] OK");
      end else begin
         $display("[first_match_ip_acl_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fmacl_pkg.sv
rtl/fmacl_ram.sv
rtl/fmacl_dp.sv
rtl/fmacl_ctrl.sv
rtl/first_match_ip_acl_unit.sv
dv/testbench.sv
